// File: src/htq_pkg.sv
// package for the hybrid three-way quicksort core
// holds transaction types, sequencer states and default sizes; no dependencies
`default_nettype none

package htq_pkg;

  // default sizes
  localparam int MAX_KEYS_DEF = 64;
  localparam int KEY_BITS_DEF = 32;
  // range stack slots and threshold register
  localparam int STACK_SLOTS  = 64;
  localparam int THR_W        = 7;
  localparam logic [THR_W-1:0] THR_RESET = 7'd65;

  // one incoming key transaction
  typedef struct packed {
    logic [31:0] key_value;
    logic        is_last;
  } key_item_t;

  // one outgoing sorted key transaction
  typedef struct packed {
    logic [31:0] sorted_key;
    logic        is_final;
  } res_item_t;

  // sequencer states
  typedef enum logic [4:0] {
    ST_LOAD,
    ST_POP,
    ST_POP_W,
    ST_INS_U,
    ST_INS_V,
    ST_INS_P,
    ST_INS_C,
    ST_PV_RA,
    ST_PV_RB,
    ST_PV_RC,
    ST_PV_CAP,
    ST_PV_MED,
    ST_PV_SW2,
    ST_DF_CHK,
    ST_DF_X,
    ST_DF_GR,
    ST_DF_GR2,
    ST_DF_LS,
    ST_DF_LS2,
    ST_PUSH1,
    ST_PUSH2,
    ST_EM_RD,
    ST_EM_W
  } state_t;

endpackage

`default_nettype wire

// File: src/htq_ram.sv
// generic simple dual-port ram, one write and one registered read per cycle
// no package dependencies
`default_nettype none

module htq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: src/hybrid_three_way_quicksort_core.sv
// hybrid three-way quicksort core: key store, range stack and sort sequencer
// depends on htq_pkg and htq_ram
//
// usage:
//   keys arrive on the key channel (key_valid / key_stall, payload key_item).
//   each transaction stores one key until the store holds MAX_KEYS keys; later
//   keys are dropped. a transaction with is_last set starts the sort; key_stall
//   stays high from then until the last sorted key sits in the output register.
//   sorted keys leave on the result channel (res_valid / res_stall), ascending,
//   the last one with is_final set. a stalled result holds its payload.
//   the threshold register is written over cfg_valid / cfg_ready (always ready)
//   and should only be written while the block is idle.
// operation:
//   loading accepts a key whenever key_valid is high. the sort runs on one key
//   ram (one write and one registered read per cycle) under a small sequencer:
//   ranges shorter than the threshold get insertion sort, longer ones a
//   three-way partition around a median-of-three pivot, whose outer parts are
//   pushed back on the range stack. each key is emitted by a ram read
//   (ST_EM_RD) and an output write (ST_EM_W) that waits while res_stall holds
//   the output register.
// reset: rst (synchronous) empties the store and stack and sets the threshold
//   to 65; no clearing pass is needed.
`default_nettype none

module hybrid_three_way_quicksort_core #(
  parameter int MAX_KEYS = htq_pkg::MAX_KEYS_DEF,
  parameter int KEY_BITS = htq_pkg::KEY_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     key_valid,
  output logic                          key_stall,
  input  wire htq_pkg::key_item_t       key_item,
  output logic                          res_valid,
  input  wire logic                     res_stall,
  output htq_pkg::res_item_t            res_item,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [htq_pkg::THR_W-1:0] cfg_data
);
  import htq_pkg::*;

  localparam int IW  = $clog2(MAX_KEYS);
  localparam int CW  = $clog2(MAX_KEYS + 1);
  localparam int SAW = $clog2(STACK_SLOTS);
  localparam int DW  = $clog2(STACK_SLOTS + 1);
  localparam int SEW = 2 * IW;

  state_t state, state_next;

  logic [CW-1:0]       count, count_next;
  logic [DW-1:0]       depth, depth_next;
  logic [IW-1:0]       lo, lo_next, hi, hi_next, mid, mid_next;
  logic [CW-1:0]       u, u_next, p, p_next, k, k_next;
  logic [CW-1:0]       l, l_next, i, i_next, r, r_next;
  logic [KEY_BITS-1:0] x, x_next, a, a_next, b, b_next, c, c_next;
  logic [KEY_BITS-1:0] pv, pv_next, sw, sw_next;
  logic [THR_W-1:0]    thr;
  res_item_t           res_next;
  logic                res_valid_next;

  // memory ports
  logic                k_we;
  logic [IW-1:0]       k_waddr, k_raddr;
  logic [KEY_BITS-1:0] k_wdata, k_rdata;
  logic                s_we;
  logic [SAW-1:0]      s_waddr, s_raddr;
  logic [SEW-1:0]      s_wdata, s_rdata;

  // helper values
  logic [KEY_BITS-1:0] kin, med, m_a, m_b;
  logic [CW-1:0]       n_new, len, pop_lo, pop_hi;
  logic [IW:0]         mid_sum;
  logic                out_free;

  htq_ram #(.WIDTH(KEY_BITS), .DEPTH(MAX_KEYS)) u_key_ram (
    .clk   (clk),
    .we    (k_we),
    .waddr (k_waddr),
    .wdata (k_wdata),
    .raddr (k_raddr),
    .rdata (k_rdata)
  );

  htq_ram #(.WIDTH(SEW), .DEPTH(STACK_SLOTS)) u_stack_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  assign cfg_ready = 1'b1;
  assign kin       = KEY_BITS'(key_item.key_value);
  assign out_free  = !res_valid || !res_stall;

  // median of first, middle and last key
  always_comb begin
    m_a = (a > b) ? b : a;
    m_b = (a > b) ? a : b;
    if (m_b > c) begin
      m_b = c;
    end
    med = (m_a > m_b) ? m_a : m_b;
  end

  // popped range fields
  assign pop_lo  = CW'(s_rdata[SEW-1:IW]);
  assign pop_hi  = CW'(s_rdata[IW-1:0]);
  assign len     = pop_hi - pop_lo + CW'(1);
  assign mid_sum = {1'b0, s_rdata[SEW-1:IW]} + {1'b0, s_rdata[IW-1:0]};
  assign n_new   = count + ((count < CW'(MAX_KEYS)) ? CW'(1) : CW'(0));

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // control and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      depth     <= '0;
      res_valid <= 1'b0;
      thr       <= THR_RESET;
    end else begin
      count     <= count_next;
      depth     <= depth_next;
      res_valid <= res_valid_next;
      if (cfg_valid && cfg_ready) begin
        thr <= cfg_data;
      end
    end
    lo       <= lo_next;
    hi       <= hi_next;
    mid      <= mid_next;
    u        <= u_next;
    p        <= p_next;
    k        <= k_next;
    l        <= l_next;
    i        <= i_next;
    r        <= r_next;
    x        <= x_next;
    a        <= a_next;
    b        <= b_next;
    c        <= c_next;
    pv       <= pv_next;
    sw       <= sw_next;
    res_item <= res_next;
  end

  // sequencer: next state, memory control and register updates
  always_comb begin
    state_next     = state;
    count_next     = count;
    depth_next     = depth;
    lo_next        = lo;
    hi_next        = hi;
    mid_next       = mid;
    u_next         = u;
    p_next         = p;
    k_next         = k;
    l_next         = l;
    i_next         = i;
    r_next         = r;
    x_next         = x;
    a_next         = a;
    b_next         = b;
    c_next         = c;
    pv_next        = pv;
    sw_next        = sw;
    res_next       = res_item;
    res_valid_next = res_valid && res_stall;
    key_stall      = 1'b1;
    k_we           = 1'b0;
    k_waddr        = '0;
    k_wdata        = x;
    k_raddr        = '0;
    s_we           = 1'b0;
    s_waddr        = depth[SAW-1:0];
    s_wdata        = '0;
    s_raddr        = '0;
    case (state)
      ST_LOAD: begin
        key_stall = 1'b0;
        if (key_valid) begin
          if (count < CW'(MAX_KEYS)) begin
            k_we    = 1'b1;
            k_waddr = count[IW-1:0];
            k_wdata = kin;
          end
          count_next = n_new;
          if (key_item.is_last) begin
            k_next = '0;
            if (n_new < CW'(2)) begin
              state_next = ST_EM_RD;
            end else begin
              s_we       = 1'b1;
              s_waddr    = '0;
              s_wdata    = {IW'(0), IW'(n_new - CW'(1))};
              depth_next = DW'(1);
              state_next = ST_POP;
            end
          end
        end
      end
      // range stack
      ST_POP: begin
        if (depth == '0) begin
          state_next = ST_EM_RD;
        end else begin
          s_raddr    = SAW'(depth - DW'(1));
          depth_next = depth - DW'(1);
          state_next = ST_POP_W;
        end
      end
      ST_POP_W: begin
        lo_next  = s_rdata[SEW-1:IW];
        hi_next  = s_rdata[IW-1:0];
        mid_next = mid_sum[IW:1];
        if ({1'b0, 7'(len)} < {1'b0, thr}) begin
          u_next     = pop_lo + CW'(1);
          state_next = ST_INS_U;
        end else if (pop_lo < pop_hi) begin
          state_next = ST_PV_RA;
        end else begin
          state_next = ST_POP;
        end
      end
      // insertion sort
      ST_INS_U: begin
        if (u > CW'(hi)) begin
          state_next = ST_POP;
        end else begin
          k_raddr    = u[IW-1:0];
          p_next     = u;
          state_next = ST_INS_V;
        end
      end
      ST_INS_V: begin
        x_next     = k_rdata;
        state_next = ST_INS_P;
      end
      ST_INS_P: begin
        if (p > CW'(lo)) begin
          k_raddr    = IW'(p - CW'(1));
          state_next = ST_INS_C;
        end else begin
          k_we       = 1'b1;
          k_waddr    = p[IW-1:0];
          k_wdata    = x;
          u_next     = u + CW'(1);
          state_next = ST_INS_U;
        end
      end
      ST_INS_C: begin
        k_we    = 1'b1;
        k_waddr = p[IW-1:0];
        if (k_rdata > x) begin
          k_wdata    = k_rdata;
          p_next     = p - CW'(1);
          state_next = ST_INS_P;
        end else begin
          k_wdata    = x;
          u_next     = u + CW'(1);
          state_next = ST_INS_U;
        end
      end
      // pivot selection
      ST_PV_RA: begin
        k_raddr    = lo;
        state_next = ST_PV_RB;
      end
      ST_PV_RB: begin
        a_next     = k_rdata;
        k_raddr    = mid;
        state_next = ST_PV_RC;
      end
      ST_PV_RC: begin
        b_next     = k_rdata;
        k_raddr    = hi;
        state_next = ST_PV_CAP;
      end
      ST_PV_CAP: begin
        c_next     = k_rdata;
        state_next = ST_PV_MED;
      end
      ST_PV_MED: begin
        pv_next    = med;
        l_next     = CW'(lo);
        i_next     = CW'(lo);
        r_next     = CW'(hi);
        state_next = ST_DF_CHK;
        if (med == a) begin
          k_we       = 1'b1;
          k_waddr    = lo;
          k_wdata    = c;
          sw_next    = a;
          state_next = ST_PV_SW2;
        end else if (med == b) begin
          k_we       = 1'b1;
          k_waddr    = mid;
          k_wdata    = c;
          sw_next    = b;
          state_next = ST_PV_SW2;
        end
      end
      ST_PV_SW2: begin
        k_we       = 1'b1;
        k_waddr    = hi;
        k_wdata    = sw;
        state_next = ST_DF_CHK;
      end
      // three-way partition
      ST_DF_CHK: begin
        if (i > r) begin
          state_next = ST_PUSH1;
        end else begin
          k_raddr    = i[IW-1:0];
          state_next = ST_DF_X;
        end
      end
      ST_DF_X: begin
        x_next = k_rdata;
        if (k_rdata > pv) begin
          k_raddr    = r[IW-1:0];
          state_next = ST_DF_GR;
        end else if (k_rdata < pv) begin
          k_raddr    = l[IW-1:0];
          state_next = ST_DF_LS;
        end else begin
          i_next     = i + CW'(1);
          state_next = ST_DF_CHK;
        end
      end
      ST_DF_GR: begin
        k_we       = 1'b1;
        k_waddr    = i[IW-1:0];
        k_wdata    = k_rdata;
        state_next = ST_DF_GR2;
      end
      ST_DF_GR2: begin
        k_we    = 1'b1;
        k_waddr = r[IW-1:0];
        k_wdata = x;
        if (r == '0) begin
          state_next = ST_PUSH1;
        end else begin
          r_next     = r - CW'(1);
          state_next = ST_DF_CHK;
        end
      end
      ST_DF_LS: begin
        k_we       = 1'b1;
        k_waddr    = i[IW-1:0];
        k_wdata    = k_rdata;
        state_next = ST_DF_LS2;
      end
      ST_DF_LS2: begin
        k_we       = 1'b1;
        k_waddr    = l[IW-1:0];
        k_wdata    = x;
        l_next     = l + CW'(1);
        i_next     = i + CW'(1);
        state_next = ST_DF_CHK;
      end
      // push the outer parts
      ST_PUSH1: begin
        if (l > CW'(lo) + CW'(1) && depth < DW'(STACK_SLOTS)) begin
          s_we       = 1'b1;
          s_wdata    = {lo, IW'(l - CW'(1))};
          depth_next = depth + DW'(1);
        end
        state_next = ST_PUSH2;
      end
      ST_PUSH2: begin
        if (r + CW'(1) < CW'(hi) && depth < DW'(STACK_SLOTS)) begin
          s_we       = 1'b1;
          s_wdata    = {IW'(r + CW'(1)), hi};
          depth_next = depth + DW'(1);
        end
        state_next = ST_POP;
      end
      // emit sorted keys
      ST_EM_RD: begin
        k_raddr    = k[IW-1:0];
        state_next = ST_EM_W;
      end
      ST_EM_W: begin
        k_raddr = k[IW-1:0];
        if (out_free) begin
          res_valid_next      = 1'b1;
          res_next.sorted_key = 32'(k_rdata);
          res_next.is_final   = (k + CW'(1) == count);
          k_next              = k + CW'(1);
          if (k + CW'(1) == count) begin
            count_next = '0;
            depth_next = '0;
            state_next = ST_LOAD;
          end else begin
            state_next = ST_EM_RD;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_KEYS))
    else $error("key count beyond store size");

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= DW'(STACK_SLOTS))
    else $error("range stack overflow");

  a_part_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DF_CHK) |-> (l <= i))
    else $error("partition less pointer ahead of scan pointer");

  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    (key_valid && !key_stall && key_item.is_last) |=> key_stall)
    else $error("key channel open while sorting");

endmodule

`default_nettype wire

// File: bench/hybrid_three_way_quicksort_core_tb.sv
// testbench for the hybrid three-way quicksort core: drives key sets, sorts them
// with its own sorter model and checks every sorted key transaction in order
// depends on htq_pkg and the core rtl
`timescale 1ns / 100ps
`default_nettype none

module hybrid_three_way_quicksort_core_tb;
  import htq_pkg::*;

  localparam int STORE_DEPTH = 64;
  localparam int IDLE_LIMIT  = 40000;

  // expected sorted keys and the sorter model that fills them
  class sorted_key_board;
    logic [31:0]      store [STORE_DEPTH];
    int unsigned      count;
    int unsigned      threshold;
    res_item_t        pending [$];
    int unsigned      errors;

    function void clear();
      count = 0;
      threshold = 65;
      errors = 0;
      pending.delete();
    endfunction

    function void swap2(int unsigned a, int unsigned b);
      logic [31:0] t;
      t = store[a]; store[a] = store[b]; store[b] = t;
    endfunction

    function void insertion(int unsigned lo, int unsigned hi);
      logic [31:0] v;
      int unsigned p;
      for (int unsigned u = lo + 1; u <= hi; u++) begin
        v = store[u];
        p = u;
        while (p > lo && store[p-1] > v) begin
          store[p] = store[p-1];
          p--;
        end
        store[p] = v;
      end
    endfunction

    // three-way split around median of first, middle and last
    function void split(int unsigned lo, int unsigned hi,
                        output int unsigned el, output int unsigned eh);
      logic [31:0] a, b, c, pv;
      int unsigned md, l, r, i;
      md = (lo + hi) / 2;
      a = store[lo]; b = store[md]; c = store[hi];
      if (a > b) begin pv = a; a = b; b = pv; end
      if (b > c) b = c;
      pv = (a > b) ? a : b;
      if (pv == store[lo]) swap2(lo, hi);
      else if (pv == store[md]) swap2(md, hi);
      l = lo; r = hi; i = lo;
      while (i <= r) begin
        if (store[i] > pv) begin
          swap2(i, r);
          if (r == 0) break;
          r--;
        end else if (store[i] < pv) begin
          swap2(l, i);
          l++; i++;
        end else begin
          i++;
        end
      end
      el = l; eh = r;
    endfunction

    function void sort_keys();
      int unsigned stk_lo [$], stk_hi [$];
      int unsigned lo, hi, el, eh;
      if (count < 2) return;
      stk_lo.push_back(0); stk_hi.push_back(count - 1);
      while (stk_lo.size() > 0) begin
        lo = stk_lo.pop_back(); hi = stk_hi.pop_back();
        if (hi - lo + 1 < threshold) begin
          insertion(lo, hi);
        end else if (lo < hi) begin
          split(lo, hi, el, eh);
          if (el > lo + 1) begin stk_lo.push_back(lo); stk_hi.push_back(el - 1); end
          if (eh + 1 < hi) begin stk_lo.push_back(eh + 1); stk_hi.push_back(hi); end
        end
      end
    endfunction

    // note an accepted key transaction
    function void note_key(key_item_t it);
      res_item_t r;
      if (count < STORE_DEPTH) begin
        store[count] = it.key_value;
        count++;
      end
      if (!it.is_last) return;
      sort_keys();
      for (int unsigned k = 0; k < count; k++) begin
        r.sorted_key = store[k];
        r.is_final = (k + 1 == count);
        pending.push_back(r);
      end
      count = 0;
    endfunction

    // check one accepted result transaction
    function void check_result(res_item_t got);
      res_item_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result key=%h final=%b", $time,
                 got.sorted_key, got.is_final);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.sorted_key !== want.sorted_key) begin
        $display("%0t: sorted_key expected %h actual %h", $time,
                 want.sorted_key, got.sorted_key);
        errors++;
      end
      if (got.is_final !== want.is_final) begin
        $display("%0t: is_final expected %b actual %b", $time,
                 want.is_final, got.is_final);
        errors++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       key_valid = 1'b0;
  logic       key_stall;
  key_item_t  key_item = '0;
  logic       res_valid;
  logic       res_stall = 1'b0;
  res_item_t  res_item;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [THR_W-1:0] cfg_data = '0;

  sorted_key_board board;
  int unsigned idle_cycles = 0;

  hybrid_three_way_quicksort_core u_top (
    .clk(clk), .rst(rst),
    .key_valid(key_valid), .key_stall(key_stall), .key_item(key_item),
    .res_valid(res_valid), .res_stall(res_stall), .res_item(res_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // clock, 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // result side: sample at rising edge, random stall at falling edge
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) board.check_result(res_item);
  end

  int unsigned stall_left = 0;
  bit          stall_on = 1;
  always @(negedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      res_stall <= 1'b1;
    end else begin
      res_stall <= 1'b0;
      if (stall_on && $urandom_range(0, 3) == 0) stall_left = gap_len();
    end
  end

  // watchdog on cycles with no transaction
  always @(posedge clk) begin
    if ((key_valid && !key_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("[hybrid_three_way_quicksort_core] ERROR");
      $finish;
    end
  end

  // one key transaction, waits for acceptance; valid stays up for the next one
  task automatic send_key(logic [31:0] k, logic last, bit gaps);
    int unsigned g;
    key_item_t it;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      key_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    it.key_value = k;
    it.is_last = last;
    key_valid <= 1'b1;
    key_item <= it;
    do @(posedge clk); while (key_stall);
    board.note_key(it);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    key_valid <= 1'b0;
    while (board.pending.size() > 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_threshold(logic [THR_W-1:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    board.threshold = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_key(int unsigned mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(0, 3);
      2: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      default: return 32'h8000_0000 + $urandom_range(0, 7);
    endcase
  endfunction

  // one set of n keys, last one flagged
  task automatic send_set(int unsigned n, int unsigned mode, bit gaps);
    for (int unsigned i = 0; i < n; i++)
      send_key(rand_key(mode), i + 1 == n, gaps);
  endtask

  initial begin
    int unsigned sent;
    int unsigned n;
    logic [THR_W-1:0] thr_list [6];
    board = new();
    board.clear();
    thr_list = '{7'd0, 7'd1, 7'd2, 7'd5, 7'd16, 7'd127};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: single key, extremes, duplicates, reverse order
    send_key(32'hFFFF_FFFF, 1'b1, 0);
    send_key(32'h0, 1'b0, 0);
    send_key(32'hFFFF_FFFF, 1'b0, 0);
    send_key(32'h5555_5555, 1'b0, 0);
    send_key(32'hAAAA_AAAA, 1'b1, 0);
    write_threshold(7'd1);
    for (int i = 0; i < 6; i++) send_key(32'd100 - i, i == 5, 0);
    for (int i = 0; i < 5; i++) send_key(32'd7, i == 4, 0);
    // pause until all results are out
    wait_drained();
    write_threshold(7'd0);
    send_set(8, 1, 0);

    // store full: 64 keys, extra dropped, flag still sorts
    write_threshold(7'd127);
    for (int i = 0; i < 66; i++) send_key($urandom(), i == 65, 1);
    write_threshold(7'd2);
    for (int i = 0; i < 66; i++) send_key($urandom_range(0, 5), i == 65, 1);

    // random sets over several thresholds
    sent = 0;
    for (int ph = 0; sent < 80; ph++) begin
      write_threshold(ph % 3 == 2 ? 7'($urandom_range(0, 127)) : thr_list[ph % 6]);
      stall_on = (ph % 4 != 3);
      repeat (3) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 64) : $urandom_range(1, 12);
        send_set(n, $urandom_range(0, 3), ph % 4 != 3);
        sent += n;
      end
    end
    stall_on = 1;
    write_threshold(THR_RESET);
    send_set(10, 0, 1);
    wait_drained();
    repeat (50) @(negedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("[hybrid_three_way_quicksort_core] OK");
    end else begin
      $display("[hybrid_three_way_quicksort_core] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
